>>> src/ppc32_reloc_patch_unit_defines.svh
// assertion helpers shared by the relocation patch unit modules
// every use expects clk and arst_n in scope
`ifndef PPC32_RELOC_PATCH_UNIT_DEFINES_SVH
`define PPC32_RELOC_PATCH_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define PPCRP_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ppcrp check failed");

// consequent holds in the same cycle as the antecedent
`define PPCRP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppcrp check failed");

// consequent holds in the cycle after the antecedent
`define PPCRP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppcrp check failed");

`endif

>>> src/ppcrp_pkg.sv
`timescale 1ns / 1ps

package ppcrp_pkg;

	// status codes
	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_W32     = 3'd1;
	localparam logic [2:0] ST_W16     = 3'd2;
	localparam logic [2:0] ST_PLT     = 3'd3;
	localparam logic [2:0] ST_DTPMOD  = 3'd4;
	localparam logic [2:0] ST_COPY    = 3'd5;
	localparam logic [2:0] ST_UNKNOWN = 3'd6;

	// data formats chosen by the front end
	localparam logic [2:0] FMT_ZERO   = 3'd0;
	localparam logic [2:0] FMT_WORD   = 3'd1;
	localparam logic [2:0] FMT_LO16   = 3'd2;
	localparam logic [2:0] FMT_HI16   = 3'd3;
	localparam logic [2:0] FMT_ADDR24 = 3'd4;
	localparam logic [2:0] FMT_ADDR14 = 3'd5;
	localparam logic [2:0] FMT_BR14   = 3'd6;

	// relocation type numbers
	localparam logic [7:0] RT_NONE          = 8'd0;
	localparam logic [7:0] RT_ADDR32        = 8'd1;
	localparam logic [7:0] RT_ADDR24        = 8'd2;
	localparam logic [7:0] RT_ADDR16        = 8'd3;
	localparam logic [7:0] RT_ADDR16_LO     = 8'd4;
	localparam logic [7:0] RT_ADDR16_HI     = 8'd5;
	localparam logic [7:0] RT_ADDR16_HA     = 8'd6;
	localparam logic [7:0] RT_ADDR14        = 8'd7;
	localparam logic [7:0] RT_ADDR14_BRTAKEN = 8'd8;
	localparam logic [7:0] RT_ADDR14_BRNTAKEN = 8'd9;
	localparam logic [7:0] RT_REL24         = 8'd10;
	localparam logic [7:0] RT_COPY          = 8'd19;
	localparam logic [7:0] RT_GLOB_DAT      = 8'd20;
	localparam logic [7:0] RT_JMP_SLOT      = 8'd21;
	localparam logic [7:0] RT_RELATIVE      = 8'd22;
	localparam logic [7:0] RT_UADDR32       = 8'd24;
	localparam logic [7:0] RT_UADDR16       = 8'd25;
	localparam logic [7:0] RT_REL32         = 8'd26;
	localparam logic [7:0] RT_DTPMOD32      = 8'd68;
	localparam logic [7:0] RT_TPREL16       = 8'd69;
	localparam logic [7:0] RT_TPREL16_LO    = 8'd70;
	localparam logic [7:0] RT_TPREL16_HI    = 8'd71;
	localparam logic [7:0] RT_TPREL16_HA    = 8'd72;
	localparam logic [7:0] RT_TPREL32       = 8'd73;
	localparam logic [7:0] RT_DTPREL16      = 8'd74;
	localparam logic [7:0] RT_DTPREL16_LO   = 8'd75;
	localparam logic [7:0] RT_DTPREL16_HI   = 8'd76;
	localparam logic [7:0] RT_DTPREL16_HA   = 8'd77;
	localparam logic [7:0] RT_DTPREL32      = 8'd78;
	localparam logic [7:0] RT_IRELATIVE     = 8'd248;

	// config register indexes
	localparam logic CFG_IS_EXEC  = 1'b0;
	localparam logic CFG_GOT_MODE = 1'b1;

	// operand constants
	localparam logic [31:0] K_MINUS_8000 = 32'hffff8000;
	localparam logic [31:0] K_PLUS_8000  = 32'h00008000;
	localparam logic [31:0] K_TP_BIAS    = 32'hffff9000; // -0x7000
	localparam logic [31:0] K_TP_HA_BIAS = 32'h00001000; // -0x7000 + 0x8000
	localparam logic [31:0] M_A24_NEW    = 32'h03fffffc;
	localparam logic [31:0] M_A24_OLD    = 32'hfc000003;
	localparam logic [31:0] M_A14_NEW    = 32'h0000fffc;
	localparam logic [31:0] M_A14_OLD    = 32'hffff0003;
	localparam logic [31:0] M_BR14_OLD   = 32'hffdf0003;

	typedef struct packed {
		logic [7:0]  reloc_type;
		logic [31:0] sym_value;
		logic [31:0] addend;
		logic [31:0] patch_offset;
		logic [31:0] old_word;
		logic        tls_valid;
		logic [31:0] tls_offset;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] write_address;
		logic [31:0] patch_data;
	} out_beat_t;

	typedef struct packed {
		logic is_executable;
		logic got_mode_set;
	} cfg_t;

	// classified relocation waiting for the back end
	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  fmt;
		logic        hint;
		logic [31:0] v;
		logic [31:0] opnd;
		logic        cin;
		logic [31:0] addr;
		logic [31:0] old_word;
	} qent_t;

endpackage

>>> src/ppcrp_front.sv
`timescale 1ns / 1ps

// type decode, symbol + addend and the second operand for the back end
module ppcrp_front (
	input  ppcrp_pkg::in_beat_t beat,
	input  ppcrp_pkg::cfg_t     cfg,
	output ppcrp_pkg::qent_t    ent
);

	logic [31:0] base;
	logic [31:0] tp_opnd;
	logic        tls_ok;

	// relative takes the addend alone
	assign base    = (beat.reloc_type == ppcrp_pkg::RT_RELATIVE) ? 32'd0 : beat.sym_value;
	assign tp_opnd = beat.tls_offset + ((beat.reloc_type == ppcrp_pkg::RT_TPREL16_HA) ?
		ppcrp_pkg::K_TP_HA_BIAS : ppcrp_pkg::K_TP_BIAS);
	assign tls_ok  = cfg.is_executable & beat.tls_valid;

	always_comb begin
		ent.v        = base + beat.addend;
		ent.addr     = beat.patch_offset;
		ent.old_word = beat.old_word;
		ent.status   = ppcrp_pkg::ST_NONE;
		ent.fmt      = ppcrp_pkg::FMT_ZERO;
		ent.hint     = 1'b0;
		ent.opnd     = 32'd0;
		ent.cin      = 1'b0;
		unique case (beat.reloc_type) inside
			ppcrp_pkg::RT_NONE, ppcrp_pkg::RT_IRELATIVE: begin
			end
			ppcrp_pkg::RT_RELATIVE, ppcrp_pkg::RT_ADDR32, ppcrp_pkg::RT_GLOB_DAT,
			ppcrp_pkg::RT_UADDR32: begin
				ent.status = ppcrp_pkg::ST_W32;
				ent.fmt    = ppcrp_pkg::FMT_WORD;
			end
			ppcrp_pkg::RT_DTPREL32: begin
				ent.status = ppcrp_pkg::ST_W32;
				ent.fmt    = ppcrp_pkg::FMT_WORD;
				ent.opnd   = ppcrp_pkg::K_MINUS_8000;
			end
			ppcrp_pkg::RT_JMP_SLOT: begin
				ent.status = cfg.got_mode_set ? ppcrp_pkg::ST_W32 : ppcrp_pkg::ST_PLT;
				ent.fmt    = ppcrp_pkg::FMT_WORD;
			end
			ppcrp_pkg::RT_ADDR16, ppcrp_pkg::RT_UADDR16, ppcrp_pkg::RT_ADDR16_LO: begin
				ent.status = ppcrp_pkg::ST_W16;
				ent.fmt    = ppcrp_pkg::FMT_LO16;
			end
			ppcrp_pkg::RT_DTPREL16, ppcrp_pkg::RT_DTPREL16_LO: begin
				ent.status = ppcrp_pkg::ST_W16;
				ent.fmt    = ppcrp_pkg::FMT_LO16;
				ent.opnd   = ppcrp_pkg::K_MINUS_8000;
			end
			ppcrp_pkg::RT_ADDR16_HI, ppcrp_pkg::RT_DTPREL16_HA: begin
				ent.status = ppcrp_pkg::ST_W16;
				ent.fmt    = ppcrp_pkg::FMT_HI16;
			end
			ppcrp_pkg::RT_DTPREL16_HI: begin
				ent.status = ppcrp_pkg::ST_W16;
				ent.fmt    = ppcrp_pkg::FMT_HI16;
				ent.opnd   = ppcrp_pkg::K_MINUS_8000;
			end
			ppcrp_pkg::RT_ADDR16_HA: begin
				ent.status = ppcrp_pkg::ST_W16;
				ent.fmt    = ppcrp_pkg::FMT_HI16;
				ent.opnd   = ppcrp_pkg::K_PLUS_8000;
			end
			ppcrp_pkg::RT_ADDR24: begin
				ent.status = ppcrp_pkg::ST_W32;
				ent.fmt    = ppcrp_pkg::FMT_ADDR24;
			end
			ppcrp_pkg::RT_ADDR14: begin
				ent.status = ppcrp_pkg::ST_W32;
				ent.fmt    = ppcrp_pkg::FMT_ADDR14;
			end
			ppcrp_pkg::RT_ADDR14_BRTAKEN, ppcrp_pkg::RT_ADDR14_BRNTAKEN: begin
				ent.status = ppcrp_pkg::ST_W32;
				ent.fmt    = ppcrp_pkg::FMT_BR14;
				ent.hint   = (beat.reloc_type == ppcrp_pkg::RT_ADDR14_BRTAKEN);
			end
			ppcrp_pkg::RT_REL24: begin
				ent.status = ppcrp_pkg::ST_W32;
				ent.fmt    = ppcrp_pkg::FMT_ADDR24;
				ent.opnd   = ~beat.patch_offset;
				ent.cin    = 1'b1;
			end
			ppcrp_pkg::RT_REL32: begin
				ent.status = ppcrp_pkg::ST_W32;
				ent.fmt    = ppcrp_pkg::FMT_WORD;
				ent.opnd   = ~beat.patch_offset;
				ent.cin    = 1'b1;
			end
			ppcrp_pkg::RT_DTPMOD32: begin
				if (cfg.is_executable) begin
					ent.status = ppcrp_pkg::ST_DTPMOD;
				end
			end
			ppcrp_pkg::RT_TPREL16, ppcrp_pkg::RT_TPREL16_LO, ppcrp_pkg::RT_TPREL16_HI,
			ppcrp_pkg::RT_TPREL16_HA, ppcrp_pkg::RT_TPREL32: begin
				if (tls_ok) begin
					ent.opnd = tp_opnd;
					if (beat.reloc_type == ppcrp_pkg::RT_TPREL32) begin
						ent.status = ppcrp_pkg::ST_W32;
						ent.fmt    = ppcrp_pkg::FMT_WORD;
					end else if (beat.reloc_type == ppcrp_pkg::RT_TPREL16_HI ||
						beat.reloc_type == ppcrp_pkg::RT_TPREL16_HA) begin
						ent.status = ppcrp_pkg::ST_W16;
						ent.fmt    = ppcrp_pkg::FMT_HI16;
					end else begin
						ent.status = ppcrp_pkg::ST_W16;
						ent.fmt    = ppcrp_pkg::FMT_LO16;
					end
				end
			end
			ppcrp_pkg::RT_COPY: begin
				if (!cfg.is_executable) begin
					ent.status = ppcrp_pkg::ST_COPY;
				end
			end
			default: begin
				ent.status = ppcrp_pkg::ST_UNKNOWN;
			end
		endcase
	end

endmodule

>>> src/ppcrp_queue.sv
`timescale 1ns / 1ps
`include "ppc32_reloc_patch_unit_defines.svh"

// small fifo between front and back end
module ppcrp_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ppcrp_pkg::qent_t push_ent,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output ppcrp_pkg::qent_t pop_ent
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ppcrp_pkg::qent_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;
	assign pop_ent   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`PPCRP_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(DEPTH))
	`PPCRP_ASSERT_NEXT(a_cnt_up, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)
	`PPCRP_ASSERT_IMPL(a_ptr_match, cnt_q == '0, wr_ptr_q == rd_ptr_q)

endmodule

>>> src/ppcrp_back.sv
`timescale 1ns / 1ps
`include "ppc32_reloc_patch_unit_defines.svh"

// final add, field merge and output register
module ppcrp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ent_valid,
	input  ppcrp_pkg::qent_t      ent,
	output logic                  ent_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ppcrp_pkg::out_beat_t  out_beat
);

	logic [31:0]          w;
	logic [31:0]          data;
	logic                 out_valid_q;
	ppcrp_pkg::out_beat_t out_beat_q;
	logic                 out_nowrite;
	logic                 out_is_w16;

	assign w       = ent.v + ent.opnd + {31'd0, ent.cin};
	assign ent_pop = ent_valid & (~out_valid_q | ~out_stall);

	always_comb begin
		unique case (ent.fmt)
			ppcrp_pkg::FMT_WORD:   data = w;
			ppcrp_pkg::FMT_LO16:   data = {16'd0, w[15:0]};
			ppcrp_pkg::FMT_HI16:   data = {16'd0, w[31:16]};
			ppcrp_pkg::FMT_ADDR24: data = (w & ppcrp_pkg::M_A24_NEW) |
				(ent.old_word & ppcrp_pkg::M_A24_OLD);
			ppcrp_pkg::FMT_ADDR14: data = (w & ppcrp_pkg::M_A14_NEW) |
				(ent.old_word & ppcrp_pkg::M_A14_OLD);
			// hint bit flips with the sign of the target
			ppcrp_pkg::FMT_BR14:   data = (w & ppcrp_pkg::M_A14_NEW) |
				(ent.old_word & ppcrp_pkg::M_BR14_OLD) | {10'd0, ent.hint ^ w[31], 21'd0};
			default:               data = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= ent_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_pop) begin
			out_beat_q.status        <= ent.status;
			out_beat_q.write_address <= ent.addr;
			out_beat_q.patch_data    <= data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	// status groups seen on a valid output beat
	assign out_nowrite = out_valid_q && out_beat_q.status != ppcrp_pkg::ST_W32 &&
		out_beat_q.status != ppcrp_pkg::ST_W16 && out_beat_q.status != ppcrp_pkg::ST_PLT;
	assign out_is_w16  = out_valid_q && out_beat_q.status == ppcrp_pkg::ST_W16;

	`PPCRP_ASSERT_IMPL(a_nowrite_zero, out_nowrite, out_beat_q.patch_data == 32'd0)
	`PPCRP_ASSERT_IMPL(a_w16_upper, out_is_w16, out_beat_q.patch_data[31:16] == 16'd0)
	`PPCRP_ASSERT_NEXT(a_pop_fills, ent_pop, out_valid_q)

endmodule

>>> src/ppc32_reloc_patch_unit.sv
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | ppcrp_pkg::in_beat_t
// out     | output    | out_valid/out_stall | ppcrp_pkg::out_beat_t
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// one relocation per cycle unless out stalls; beats pass the queue and the output register
// the front decodes and adds in the accept cycle, the back does one add and the merge
// reset clears the config registers, the queue pointers and the output valid
// in_stall rises only when the queue is full; the queue fills while out is stalled
// config writes are expected only while the unit is empty

module ppc32_reloc_patch_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ppcrp_pkg::in_beat_t  in_beat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ppcrp_pkg::out_beat_t out_beat,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic                 cfg_data
);

	ppcrp_pkg::cfg_t  cfg_q;
	ppcrp_pkg::qent_t front_ent;
	ppcrp_pkg::qent_t back_ent;
	logic             q_full;
	logic             q_not_empty;
	logic             q_pop;

	// config registers, plain write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == ppcrp_pkg::CFG_IS_EXEC) begin
				cfg_q.is_executable <= cfg_data;
			end else begin
				cfg_q.got_mode_set <= cfg_data;
			end
		end
	end

	// front: classify the relocation and prepare both add operands
	ppcrp_front u_front (
		.beat (in_beat),
		.cfg  (cfg_q),
		.ent  (front_ent)
	);

	// decoupling queue; its full flag is the input stall
	ppcrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_ent  (front_ent),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_ent   (back_ent)
	);

	assign in_stall = q_full;

	// back: final add, field merge, registered result
	ppcrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent_valid (q_not_empty),
		.ent       (back_ent),
		.ent_pop   (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule
